[design/dccpb_pkg.sv]
// shared types and constants for the dcc command packet builder
package dccpb_pkg;

    // packet kinds
    localparam logic [3:0] MODE_IDLE       = 4'd0;
    localparam logic [3:0] MODE_RESET      = 4'd1;
    localparam logic [3:0] MODE_SPEED      = 4'd2;
    localparam logic [3:0] MODE_FN_GRP1    = 4'd3;
    localparam logic [3:0] MODE_FN_GRP2A   = 4'd4;
    localparam logic [3:0] MODE_FN_GRP2B   = 4'd5;
    localparam logic [3:0] MODE_FN_F13     = 4'd6;
    localparam logic [3:0] MODE_FN_F21     = 4'd7;
    localparam logic [3:0] MODE_OPS_BYTE   = 4'd8;
    localparam logic [3:0] MODE_OPS_BIT    = 4'd9;
    localparam logic [3:0] MODE_SVC_WR     = 4'd10;
    localparam logic [3:0] MODE_SVC_BIT_WR = 4'd11;
    localparam logic [3:0] MODE_SVC_VFY    = 4'd12;
    localparam logic [3:0] MODE_SVC_BIT_VF = 4'd13;

    localparam logic [13:0] ADDR_SHORT_MAX = 14'd127;
    localparam logic [13:0] ADDR_MAX       = 14'd10239;
    localparam logic [10:0] CV_MAX         = 11'd1024;

    // instruction bytes
    localparam logic [7:0] INS_SPEED128  = 8'h3f;
    localparam logic [7:0] INS_FN_GRP1   = 8'h80;
    localparam logic [7:0] INS_FN_GRP2A  = 8'hb0;
    localparam logic [7:0] INS_FN_GRP2B  = 8'ha0;
    localparam logic [7:0] INS_FN_F13    = 8'hde;
    localparam logic [7:0] INS_FN_F21    = 8'hdf;
    localparam logic [7:0] INS_OPS_BYTE  = 8'hec;
    localparam logic [7:0] INS_OPS_BIT   = 8'he8;
    localparam logic [7:0] INS_SVC_WR    = 8'h7c;
    localparam logic [7:0] INS_SVC_BIT   = 8'h78;
    localparam logic [7:0] INS_SVC_VFY   = 8'h74;
    localparam logic [7:0] BIT_OP_VERIFY = 8'he0;
    localparam logic [7:0] BIT_OP_WRITE  = 8'hf0;
    localparam logic [7:0] ADDR_LONG_TAG = 8'hc0;
    localparam logic [7:0] IDLE_BYTE     = 8'hff;

    typedef struct packed {
        logic [3:0]        mode;
        logic [13:0]       loco_address;
        logic signed [7:0] speed_value;
        logic [7:0]        function_bits;
        logic [10:0]       cv_number;
        logic [7:0]        cv_value;
        logic [2:0]        bit_position;
        logic              bit_value;
    } cmd_t;

    typedef struct packed {
        logic [5:0][7:0] pkt_byte;
        logic [2:0]      packet_length;
        logic            error_flag;
    } pkt_t;

endpackage

[design/dccpb_encode.sv]
// combinational mapping of one command to its packet bytes and check byte
module dccpb_encode
    import dccpb_pkg::*;
(
    input  cmd_t cmd,
    output pkt_t pkt
);

    logic       has_addr;
    logic       addr_ok;
    logic       cv_ok;
    logic       err;
    logic       addr_long;
    logic [7:0] addr_b0;
    logic [2:0][7:0] ins;
    logic [1:0] ins_cnt;
    logic [4:0][7:0] body;
    logic [2:0] body_len;
    logic [7:0] chk;
    logic [9:0] cv_idx;
    logic [7:0] spd_raw;
    logic [7:0] spd_neg;
    logic [7:0] bitop;

    assign spd_raw   = cmd.speed_value;
    assign spd_neg   = 8'd0 - spd_raw;
    assign cv_idx    = 10'(cmd.cv_number - 11'd1);
    assign bitop     = {4'd0, cmd.bit_value, cmd.bit_position};
    assign addr_ok   = cmd.loco_address <= ADDR_MAX;
    assign cv_ok     = (cmd.cv_number != 11'd0) && (cmd.cv_number <= CV_MAX);
    assign has_addr  = cmd.mode inside {[MODE_SPEED:MODE_OPS_BIT]};
    assign addr_long = cmd.loco_address > ADDR_SHORT_MAX;
    assign addr_b0   = addr_long ? (ADDR_LONG_TAG | {2'b00, cmd.loco_address[13:8]})
                                 : cmd.loco_address[7:0];

    // instruction and data bytes that follow the address; unused ones stay zero
    always_comb begin
        ins     = '0;
        ins_cnt = 2'd0;
        err     = 1'b0;
        case (cmd.mode)
            MODE_IDLE: begin
                ins[0] = IDLE_BYTE;
                ins_cnt = 2'd2;
            end
            MODE_RESET: begin
                ins_cnt = 2'd2;
            end
            MODE_SPEED: begin
                ins[0] = INS_SPEED128;
                ins[1] = spd_raw[7] ? {1'b0, spd_neg[6:0]} : (spd_raw | 8'h80);
                ins_cnt = 2'd2;
                err = !addr_ok || (spd_raw == 8'h80);
            end
            MODE_FN_GRP1: begin
                ins[0] = INS_FN_GRP1 | {3'd0, cmd.function_bits[4:0]};
                ins_cnt = 2'd1;
                err = !addr_ok;
            end
            MODE_FN_GRP2A: begin
                ins[0] = INS_FN_GRP2A | {4'd0, cmd.function_bits[3:0]};
                ins_cnt = 2'd1;
                err = !addr_ok;
            end
            MODE_FN_GRP2B: begin
                ins[0] = INS_FN_GRP2B | {4'd0, cmd.function_bits[3:0]};
                ins_cnt = 2'd1;
                err = !addr_ok;
            end
            MODE_FN_F13, MODE_FN_F21: begin
                ins[0] = (cmd.mode == MODE_FN_F13) ? INS_FN_F13 : INS_FN_F21;
                ins[1] = cmd.function_bits;
                ins_cnt = 2'd2;
                err = !addr_ok;
            end
            MODE_OPS_BYTE: begin
                ins[0] = INS_OPS_BYTE | {6'd0, cv_idx[9:8]};
                ins[1] = cv_idx[7:0];
                ins[2] = cmd.cv_value;
                ins_cnt = 2'd3;
                err = !addr_ok || !cv_ok;
            end
            MODE_OPS_BIT: begin
                ins[0] = INS_OPS_BIT | {6'd0, cv_idx[9:8]};
                ins[1] = cv_idx[7:0];
                ins[2] = BIT_OP_WRITE | bitop;
                ins_cnt = 2'd3;
                err = !addr_ok || !cv_ok;
            end
            MODE_SVC_WR, MODE_SVC_VFY: begin
                ins[0] = ((cmd.mode == MODE_SVC_WR) ? INS_SVC_WR : INS_SVC_VFY)
                         | {6'd0, cv_idx[9:8]};
                ins[1] = cv_idx[7:0];
                ins[2] = cmd.cv_value;
                ins_cnt = 2'd3;
                err = !cv_ok;
            end
            MODE_SVC_BIT_WR, MODE_SVC_BIT_VF: begin
                ins[0] = INS_SVC_BIT | {6'd0, cv_idx[9:8]};
                ins[1] = cv_idx[7:0];
                ins[2] = ((cmd.mode == MODE_SVC_BIT_WR) ? BIT_OP_WRITE : BIT_OP_VERIFY)
                         | bitop;
                ins_cnt = 2'd3;
                err = !cv_ok;
            end
            default: begin
                err = 1'b1;
            end
        endcase
    end

    // splice address bytes in front of the instruction bytes
    always_comb begin
        if (!has_addr) begin
            body     = {8'd0, 8'd0, ins[2], ins[1], ins[0]};
            body_len = {1'b0, ins_cnt};
        end else if (!addr_long) begin
            body     = {8'd0, ins[2], ins[1], ins[0], addr_b0};
            body_len = {1'b0, ins_cnt} + 3'd1;
        end else begin
            body     = {ins[2], ins[1], ins[0], cmd.loco_address[7:0], addr_b0};
            body_len = {1'b0, ins_cnt} + 3'd2;
        end
    end

    assign chk = body[0] ^ body[1] ^ body[2] ^ body[3] ^ body[4];

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            if (err) begin
                pkt.pkt_byte[i] = 8'd0;
            end else if (3'(i) < body_len) begin
                pkt.pkt_byte[i] = body[i];
            end else if (3'(i) == body_len) begin
                pkt.pkt_byte[i] = chk;
            end else begin
                pkt.pkt_byte[i] = 8'd0;
            end
        end
        // the body never exceeds five bytes, so the last byte is only ever the check
        pkt.pkt_byte[5]   = (!err && body_len == 3'd5) ? chk : 8'd0;
        pkt.packet_length = err ? 3'd0 : body_len + 3'd1;
        pkt.error_flag    = err;
    end

endmodule

[design/dcc_command_packet_builder.sv]
// top level: registered command stream in, complete dcc packet stream out
// Takes one command per transfer and returns one packet per command. A command
// goes into an input register, is encoded by a short combinational path and
// lands in an output register, from which its packet is presented; a new command
// can be taken in every cycle while the downstream side accepts packets. The
// output register keeps the packet while the downstream side stalls. Error
// commands still produce a transfer with m_tuser set and an all-zero packet.
module dcc_command_packet_builder
    import dccpb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata from bit 0: mode[3:0], loco_address[13:0], speed_value[7:0],
    // function_bits[7:0], cv_number[10:0], cv_value[7:0], bit_position[2:0],
    // bit_value, zero fill
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // m_tdata from bit 0: pkt_byte0..pkt_byte5 [7:0] each, packet_length[2:0],
    // zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    // m_tuser: error_flag
    output logic        m_tuser
);

    cmd_t cmd_reg;
    logic cmd_vld_reg;
    pkt_t pkt_reg;
    logic pkt_vld_reg;
    pkt_t pkt_next;
    cmd_t cmd_next;
    logic out_free;
    logic advance;

    assign cmd_next = '{
        mode:          s_tdata[3:0],
        loco_address:  s_tdata[17:4],
        speed_value:   s_tdata[25:18],
        function_bits: s_tdata[33:26],
        cv_number:     s_tdata[44:34],
        cv_value:      s_tdata[52:45],
        bit_position:  s_tdata[55:53],
        bit_value:     s_tdata[56]
    };

    assign out_free = !pkt_vld_reg || m_tready;
    assign advance  = cmd_vld_reg && out_free;
    assign s_tready = !cmd_vld_reg || out_free;

    dccpb_encode u_encode (
        .cmd (cmd_reg),
        .pkt (pkt_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_vld_reg <= 1'b0;
            pkt_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                cmd_vld_reg <= s_tvalid;
            end
            if (out_free) begin
                pkt_vld_reg <= cmd_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg <= cmd_next;
        end
        if (advance) begin
            pkt_reg <= pkt_next;
        end
    end

    assign m_tvalid = pkt_vld_reg;
    assign m_tdata  = {5'd0, pkt_reg.packet_length, pkt_reg.pkt_byte};
    assign m_tuser  = pkt_reg.error_flag;

endmodule
